// ----- sv/trqs_pkg.sv -----
`timescale 1ns / 1ps
// Shared codes for the thread ready queue scheduler: commands, thread states,
// result status codes and configuration register indexes. No dependencies.
package trqs_pkg;

   localparam logic [2:0] CMD_CREATE = 3'd0;
   localparam logic [2:0] CMD_YIELD  = 3'd1;
   localparam logic [2:0] CMD_YTO    = 3'd2;
   localparam logic [2:0] CMD_EXIT   = 3'd3;
   localparam logic [2:0] CMD_JOIN   = 3'd4;
   localparam logic [2:0] CMD_CANCEL = 3'd5;

   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_READY = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_ENDED = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_ERR  = 2'd1;
   localparam logic [1:0] STAT_HALT = 2'd2;
   localparam logic [1:0] STAT_PEND = 2'd3;

   localparam logic REG_MODE = 1'b0;
   localparam logic REG_SEED = 1'b1;

endpackage

// ----- sv/trqs_mod.sv -----
`timescale 1ns / 1ps
// Bit-serial remainder unit: one restoring step per cycle over the dividend.
// Standalone; used by the scheduler for the random pick index.
module trqs_mod #(
   parameter int DW = 16,
   parameter int RW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [RW-1:0] divisor,
   output logic          done,
   output logic [RW-1:0] rem
);
   localparam int CNTW = $clog2(DW + 1);

   logic [DW-1:0]   quo_ff;
   logic [RW:0]     rem_ff;
   logic [RW:0]     rem_in;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [RW:0]     shifted;

   always_comb begin
      shifted = {rem_ff[RW-1:0], quo_ff[DW-1]};
      if (shifted >= {1'b0, divisor}) begin
         rem_in = shifted - {1'b0, divisor};
      end else begin
         rem_in = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNTW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNTW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_ff << 1;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff[RW-1:0];

endmodule

// ----- sv/thread_ready_queue_scheduler.sv -----
`timescale 1ns / 1ps
// Thread ready queue scheduler top level: command sequencer, thread state and
// ready ring memories, configuration port. Depends on trqs_pkg and trqs_mod.
//
// Usage: a command (req_cmd, req_target_tid) is transferred when req_valid is
// high and req_stall is low. Exactly one result (rsp_status, rsp_value_tid,
// rsp_current_tid) is transferred later on the rsp channel.
// A create searches the ids from the lowest up for a free one; a random pick
// runs the serial remainder step and then a walk that closes the gap in the
// ring, one entry per cycle. The sequencer handles one command at a time; the
// time is set by the single-ported memory walks and the serial remainder unit.
// The result is offered at the edge that returns the sequencer to idle.
// req_stall is low only while the sequencer is idle; a finished result waits
// in the output register, so a new command may be taken while rsp is stalled,
// and its own result waits until the output register is free.
// After reset thread 1 runs, all other ids are free, the ring is empty, the
// pick mode is first-come first-served and the random seed is 1. The APB port
// holds sched_mode at address 0 and random_seed at address 4; writing the
// seed reloads the random generator. Configure only while idle.
module thread_ready_queue_scheduler #(
   parameter int MAX_THREADS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [4:0] req_target_tid,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [4:0] rsp_value_tid,
   output logic [4:0] rsp_current_tid,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import trqs_pkg::*;

   localparam int N  = MAX_THREADS;
   localparam int IW = $clog2(N);
   localparam int TW = $clog2(N + 1);
   localparam int CW = $clog2(N + 1);
   localparam logic [CW-1:0] N_CNT = CW'(N);
   localparam logic [IW-1:0] I_LAST = IW'(N - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_CR_CHK = 4'd2;
   localparam logic [3:0] S_ST_CHK = 4'd3;
   localparam logic [3:0] S_YA     = 4'd4;
   localparam logic [3:0] S_PICK   = 4'd5;
   localparam logic [3:0] S_MOD    = 4'd6;
   localparam logic [3:0] S_TK_RD  = 4'd7;
   localparam logic [3:0] S_TK_V   = 4'd8;
   localparam logic [3:0] S_SH_WR  = 4'd9;
   localparam logic [3:0] S_AFTER  = 4'd10;
   localparam logic [3:0] S_YT_W2  = 4'd11;
   localparam logic [3:0] S_RM_RD  = 4'd12;
   localparam logic [3:0] S_RM_CHK = 4'd13;
   localparam logic [3:0] S_FIN    = 4'd14;

   localparam logic [2:0] RET_YIELD  = 3'd0;
   localparam logic [2:0] RET_JOIN   = 3'd1;
   localparam logic [2:0] RET_EXIT   = 3'd2;
   localparam logic [2:0] RET_YTO    = 3'd3;
   localparam logic [2:0] RET_CANCEL = 3'd4;

   function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] x);
      return (x == I_LAST) ? '0 : x + 1'b1;
   endfunction

   function automatic logic [IW-1:0] dec_idx(input logic [IW-1:0] x);
      return (x == '0) ? I_LAST : x - 1'b1;
   endfunction

   function automatic logic [IW-1:0] tid_idx(input logic [TW-1:0] t);
      logic [TW-1:0] d;
      d = t - TW'(1);
      return IW'(d);
   endfunction

   // State registers.
   logic [3:0]    state_ff, state_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [4:0]    tgt_ff, tgt_in;
   logic [IW-1:0] k_ff, k_in;
   logic [IW-1:0] j_ff, j_in;
   logic [TW-1:0] v_ff, v_in;
   logic [2:0]    ret_ff, ret_in;
   logic [1:0]    status_ff, status_in;
   logic [TW-1:0] val_ff, val_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [TW-1:0] run_ff, run_in;
   logic [15:0]   lfsr_ff, lfsr_in;
   logic          halted_ff, halted_in;
   logic          mode_ff;
   logic [15:0]   seed_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [TW-1:0] rsp_val_ff;
   logic [TW-1:0] rsp_cur_ff;

   // Memories.
   logic [TW-1:0] ring_mem [N];
   logic [1:0]    st_mem [N];
   logic [N-1:0]  st_valid_ff;
   logic [TW-1:0] ring_rd_ff;
   logic [1:0]    st_rd_ff;
   logic          st_rv_ff;
   logic          st_rz_ff;

   logic          ring_we;
   logic [IW-1:0] ring_waddr, ring_raddr;
   logic [TW-1:0] ring_wdata;
   logic          st_we;
   logic [IW-1:0] st_waddr, st_raddr;
   logic [1:0]    st_wdata;

   logic          mod_start, mod_done;
   logic [CW-1:0] mod_rem;

   logic          cfg_wr;
   logic          tgt_ok;
   logic [TW-1:0] tgt_w;
   logic [1:0]    st_cur;
   logic [15:0]   lfsr_adv;
   logic [CW-1:0] j1, j2;
   logic          fin_go;

   function automatic logic [IW-1:0] pos(input logic [IW-1:0] h, input logic [IW-1:0] x);
      logic [IW:0] s;
      s = {1'b0, h} + {1'b0, x};
      if (s >= (IW+1)'(N)) begin
         s = s - (IW+1)'(N);
      end
      return s[IW-1:0];
   endfunction

   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_SEED) ? {16'd0, seed_ff} : {31'd0, mode_ff};

   assign tgt_ok   = (tgt_ff != 5'd0) && (int'(tgt_ff) <= N);
   assign tgt_w    = TW'(tgt_ff);
   assign st_cur   = st_rv_ff ? st_rd_ff : (st_rz_ff ? ST_RUN : ST_FREE);
   assign lfsr_adv = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};
   assign j1       = CW'(j_ff) + CW'(1);
   assign j2       = CW'(j_ff) + CW'(2);
   assign fin_go   = !rsp_valid_ff || !rsp_stall;

   trqs_mod #(.DW(16), .RW(CW)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (lfsr_adv),
      .divisor  (count_ff),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      tgt_in     = tgt_ff;
      k_in       = k_ff;
      j_in       = j_ff;
      v_in       = v_ff;
      ret_in     = ret_ff;
      status_in  = status_ff;
      val_in     = val_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      run_in     = run_ff;
      lfsr_in    = lfsr_ff;
      halted_in  = halted_ff;
      ring_we    = 1'b0;
      ring_waddr = tail_ff;
      ring_wdata = run_ff;
      ring_raddr = pos(head_ff, k_ff);
      st_we      = 1'b0;
      st_waddr   = tid_idx(run_ff);
      st_wdata   = ST_READY;
      st_raddr   = tid_idx(tgt_w);
      mod_start  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               tgt_in = req_target_tid;
               if (halted_ff) begin
                  status_in = STAT_HALT;
                  val_in    = '0;
                  state_in  = S_FIN;
               end else begin
                  state_in = S_DISP;
               end
            end
         end
         S_DISP: begin
            status_in = STAT_ERR;
            val_in    = '0;
            state_in  = S_FIN;
            case (cmd_ff)
               CMD_CREATE: begin
                  k_in     = '0;
                  st_raddr = '0;
                  state_in = S_CR_CHK;
               end
               CMD_YIELD: begin
                  ret_in   = RET_YIELD;
                  state_in = S_YA;
               end
               CMD_YTO: begin
                  if (tgt_ok && tgt_w == run_ff) begin
                     status_in = STAT_OK;
                     val_in    = tgt_w;
                  end else if (tgt_ok) begin
                     state_in = S_ST_CHK;
                  end
               end
               CMD_EXIT: begin
                  st_we    = 1'b1;
                  st_wdata = ST_ENDED;
                  ret_in   = RET_EXIT;
                  if (count_ff == '0) begin
                     halted_in = 1'b1;
                     run_in    = '0;
                     status_in = STAT_HALT;
                  end else begin
                     state_in = S_PICK;
                  end
               end
               CMD_JOIN, CMD_CANCEL: begin
                  if (tgt_ok && tgt_w != run_ff) begin
                     state_in = S_ST_CHK;
                  end
               end
               default: begin
               end
            endcase
         end
         S_CR_CHK: begin
            if (st_cur == ST_FREE) begin
               if (count_ff == N_CNT) begin
                  status_in = STAT_ERR;
                  val_in    = '0;
               end else begin
                  ring_we    = 1'b1;
                  ring_wdata = TW'(k_ff) + TW'(1);
                  tail_in    = inc_idx(tail_ff);
                  count_in   = count_ff + 1'b1;
                  st_we      = 1'b1;
                  st_waddr   = k_ff;
                  st_wdata   = ST_READY;
                  status_in  = STAT_OK;
                  val_in     = TW'(k_ff) + TW'(1);
               end
               state_in = S_FIN;
            end else if (k_ff == I_LAST) begin
               status_in = STAT_ERR;
               val_in    = '0;
               state_in  = S_FIN;
            end else begin
               k_in     = k_ff + 1'b1;
               st_raddr = k_ff + 1'b1;
            end
         end
         S_ST_CHK: begin
            status_in = STAT_ERR;
            val_in    = '0;
            state_in  = S_FIN;
            k_in      = '0;
            case (cmd_ff)
               CMD_YTO: begin
                  if (st_cur == ST_READY && count_ff != '0) begin
                     ret_in   = RET_YTO;
                     state_in = S_RM_RD;
                  end
               end
               CMD_JOIN: begin
                  if (st_cur == ST_ENDED) begin
                     st_we     = 1'b1;
                     st_waddr  = tid_idx(tgt_w);
                     st_wdata  = ST_FREE;
                     status_in = STAT_OK;
                     val_in    = tgt_w;
                  end else if (st_cur != ST_FREE) begin
                     ret_in   = RET_JOIN;
                     state_in = S_YA;
                  end
               end
               default: begin
                  if (st_cur == ST_RUN) begin
                     st_we     = 1'b1;
                     st_waddr  = tid_idx(tgt_w);
                     st_wdata  = ST_ENDED;
                     status_in = STAT_OK;
                     val_in    = tgt_w;
                  end else if (st_cur == ST_READY && count_ff != '0) begin
                     ret_in   = RET_CANCEL;
                     state_in = S_RM_RD;
                  end
               end
            endcase
         end
         S_YA: begin
            // The caller joins the ring first, so the pick always finds someone.
            if (count_ff == N_CNT) begin
               status_in = STAT_ERR;
               val_in    = '0;
               state_in  = S_FIN;
            end else begin
               ring_we  = 1'b1;
               tail_in  = inc_idx(tail_ff);
               count_in = count_ff + 1'b1;
               st_we    = 1'b1;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (mode_ff) begin
               lfsr_in   = lfsr_adv;
               mod_start = 1'b1;
               state_in  = S_MOD;
            end else begin
               k_in     = '0;
               state_in = S_TK_RD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               k_in     = IW'(mod_rem);
               state_in = S_TK_RD;
            end
         end
         S_TK_RD: begin
            j_in     = k_ff;
            state_in = S_TK_V;
         end
         S_TK_V: begin
            v_in = ring_rd_ff;
            if (k_ff == '0) begin
               head_in  = inc_idx(head_ff);
               count_in = count_ff - 1'b1;
               state_in = S_AFTER;
            end else if (j1 < count_ff) begin
               ring_raddr = pos(head_ff, IW'(j1));
               state_in   = S_SH_WR;
            end else begin
               tail_in  = dec_idx(tail_ff);
               count_in = count_ff - 1'b1;
               state_in = S_AFTER;
            end
         end
         S_SH_WR: begin
            // Close the gap: each entry moves one place toward the head.
            ring_we    = 1'b1;
            ring_waddr = pos(head_ff, j_ff);
            ring_wdata = ring_rd_ff;
            j_in       = j_ff + 1'b1;
            if (j2 < count_ff) begin
               ring_raddr = pos(head_ff, IW'(j2));
            end else begin
               tail_in  = dec_idx(tail_ff);
               count_in = count_ff - 1'b1;
               state_in = S_AFTER;
            end
         end
         S_AFTER: begin
            state_in = S_FIN;
            case (ret_ff)
               RET_YTO: begin
                  ring_we  = 1'b1;
                  tail_in  = inc_idx(tail_ff);
                  count_in = count_ff + 1'b1;
                  st_we    = 1'b1;
                  state_in = S_YT_W2;
               end
               RET_CANCEL: begin
                  st_we     = 1'b1;
                  st_waddr  = tid_idx(tgt_w);
                  st_wdata  = ST_ENDED;
                  status_in = STAT_OK;
                  val_in    = tgt_w;
               end
               default: begin
                  st_we     = 1'b1;
                  st_waddr  = tid_idx(v_ff);
                  st_wdata  = ST_RUN;
                  run_in    = v_ff;
                  status_in = (ret_ff == RET_JOIN) ? STAT_PEND : STAT_OK;
                  val_in    = v_ff;
               end
            endcase
         end
         S_YT_W2: begin
            st_we     = 1'b1;
            st_waddr  = tid_idx(tgt_w);
            st_wdata  = ST_RUN;
            run_in    = tgt_w;
            status_in = STAT_OK;
            val_in    = tgt_w;
            state_in  = S_FIN;
         end
         S_RM_RD: begin
            state_in = S_RM_CHK;
         end
         S_RM_CHK: begin
            if (ring_rd_ff == tgt_w) begin
               state_in = S_TK_RD;
            end else if (CW'(k_ff) + CW'(1) == count_ff) begin
               status_in = STAT_ERR;
               val_in    = '0;
               state_in  = S_FIN;
            end else begin
               k_in       = k_ff + 1'b1;
               ring_raddr = pos(head_ff, k_ff + 1'b1);
            end
         end
         S_FIN: begin
            if (fin_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Seed write reloads the LFSR; the user keeps it to sequencer idle, unenforced.
      if (cfg_wr && paddr[2] == REG_SEED) begin
         lfsr_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         run_ff       <= TW'(1);
         halted_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         seed_ff      <= 16'd1;
         lfsr_ff      <= 16'd1;
         rsp_valid_ff <= 1'b0;
         st_valid_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         run_ff    <= run_in;
         halted_ff <= halted_in;
         lfsr_ff   <= lfsr_in;
         if (cfg_wr) begin
            if (paddr[2] == REG_MODE) begin
               mode_ff <= pwdata[0];
            end else begin
               seed_ff <= pwdata[15:0];
            end
         end
         if (st_we) begin
            st_valid_ff[st_waddr] <= 1'b1;
         end
         if (state_ff == S_FIN && fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      tgt_ff    <= tgt_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      v_ff      <= v_in;
      ret_ff    <= ret_in;
      status_ff <= status_in;
      val_ff    <= val_in;
      if (state_ff == S_FIN && fin_go) begin
         rsp_status_ff <= status_ff;
         rsp_val_ff    <= val_ff;
         rsp_cur_ff    <= halted_ff ? '0 : run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_rd_ff <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_waddr] <= st_wdata;
      end
      st_rd_ff <= st_mem[st_raddr];
      st_rv_ff <= st_valid_ff[st_raddr];
      st_rz_ff <= (st_raddr == '0);
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_tid   = 5'(rsp_val_ff);
   assign rsp_current_tid = 5'(rsp_cur_ff);

endmodule
